// ----- design/rgbq_pkg.sv -----
// Package for the RGB565 to int8 pixel unit: request/result types, config
// register indexes, frame geometry and the plane offset function.
// No dependencies.
`default_nettype none
package rgbq_pkg;

    localparam int CAMERA_WIDTH       = 128;
    localparam int CAMERA_HEIGHT      = 128;
    localparam int MODEL_IMAGE_WIDTH  = 160;
    localparam int MODEL_IMAGE_HEIGHT = 128;
    localparam int LEFT_MARGIN        = (MODEL_IMAGE_WIDTH - CAMERA_WIDTH) / 2;
    localparam int TOP_MARGIN         = (MODEL_IMAGE_HEIGHT - CAMERA_HEIGHT) / 2;

    localparam int PIPE_DEPTH = 4;

    localparam logic [1:0] CFG_QUANT_MULTIPLIER = 2'd0;
    localparam logic [1:0] CFG_QUANT_SHIFT      = 2'd1;
    localparam logic [1:0] CFG_ZERO_POINT       = 2'd2;

    // Base shift: log2 of half the levels of the field
    localparam logic [5:0] SHIFT_5BIT = 6'd4;
    localparam logic [5:0] SHIFT_6BIT = 6'd5;

    typedef struct packed {
        logic [15:0] pixel_word;
        logic [13:0] pixel_index;
    } t_pixel_req;

    typedef struct packed {
        logic [14:0]        plane_offset;
        logic signed [7:0]  red_value;
        logic signed [7:0]  green_value;
        logic signed [7:0]  blue_value;
    } t_pixel_res;

    typedef struct packed {
        logic [5:0] delta;
        logic       neg;
        logic [5:0] shamt;
    } t_chan_op;

    function automatic logic [14:0] plane_offset_of(input logic [13:0] idx);
        logic [13:0]        row;
        logic [13:0]        col;
        logic signed [31:0] off;
        row = 14'(idx / 14'(CAMERA_WIDTH));
        col = 14'(idx % 14'(CAMERA_WIDTH));
        off = (32'(TOP_MARGIN) + $signed({18'd0, row})) * 32'(MODEL_IMAGE_WIDTH)
              + 32'(LEFT_MARGIN) + $signed({18'd0, col});
        return off[14:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/rgbq_decode.sv -----
// First pipeline stage: split the RGB565 word into channel distances from
// mid-scale and compute the padded plane offset. Uses rgbq_pkg.
`default_nettype none
module rgbq_decode (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire rgbq_pkg::t_pixel_req i_req,
    input  wire logic [4:0]           i_quant_shift,
    output logic                      o_valid,
    output rgbq_pkg::t_chan_op        o_red,
    output rgbq_pkg::t_chan_op        o_green,
    output rgbq_pkg::t_chan_op        o_blue,
    output logic [14:0]               o_offset
);
    import rgbq_pkg::*;

    logic        r_valid;
    t_chan_op    r_red, r_green, r_blue;
    t_chan_op    n_red, n_green, n_blue;
    logic [14:0] r_offset;
    logic [4:0]  red_code, blue_code;
    logic [5:0]  green_code;

    always_comb begin
        red_code   = i_req.pixel_word[15:11];
        green_code = i_req.pixel_word[10:5];
        blue_code  = i_req.pixel_word[4:0];

        n_red.neg   = ~red_code[4];
        n_red.delta = red_code[4] ? {1'b0, red_code - 5'd16}
                                  : 6'(6'd16 - {1'b0, red_code});
        n_red.shamt = SHIFT_5BIT + {1'b0, i_quant_shift};

        n_green.neg   = ~green_code[5];
        n_green.delta = green_code[5] ? (green_code - 6'd32)
                                      : 6'(7'd32 - {1'b0, green_code});
        n_green.shamt = SHIFT_6BIT + {1'b0, i_quant_shift};

        n_blue.neg   = ~blue_code[4];
        n_blue.delta = blue_code[4] ? {1'b0, blue_code - 5'd16}
                                    : 6'(6'd16 - {1'b0, blue_code});
        n_blue.shamt = SHIFT_5BIT + {1'b0, i_quant_shift};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
        r_offset <= plane_offset_of(i_req.pixel_index);
    end

    assign o_valid  = r_valid;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_offset = r_offset;

endmodule
`default_nettype wire

// ----- design/rgbq_chan.sv -----
// Three-stage channel quantizer: multiply, shift and clip the magnitude,
// then apply sign and zero point with saturation. Uses rgbq_pkg.
`default_nettype none
module rgbq_chan (
    input  wire logic               i_clk,
    input  wire rgbq_pkg::t_chan_op i_op,
    input  wire logic [31:0]        i_quant_multiplier,
    input  wire logic signed [7:0]  i_zero_point,
    output logic signed [7:0]       o_value
);
    import rgbq_pkg::*;

    logic [37:0]        r_prod;
    logic               r_neg1, r_neg2;
    logic [5:0]         r_shamt;
    logic [8:0]         r_mag;
    logic [8:0]         n_mag;
    logic [37:0]        shifted;
    logic signed [10:0] signed_mag;
    logic signed [10:0] sum;
    logic signed [7:0]  n_value;
    logic signed [7:0]  r_value;

    always_comb begin
        shifted    = r_prod >> r_shamt;
        n_mag      = (|shifted[37:8]) ? 9'd256 : {1'b0, shifted[7:0]};
        signed_mag = r_neg2 ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
        sum        = signed_mag + 11'(i_zero_point);
        if (sum > 11'sd127) begin
            n_value = 8'sd127;
        end else if (sum < -11'sd128) begin
            n_value = -8'sd128;
        end else begin
            n_value = sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= 38'(i_op.delta) * 38'(i_quant_multiplier);
        r_shamt <= i_op.shamt;
        r_neg1  <= i_op.neg;
        r_mag   <= n_mag;
        r_neg2  <= r_neg1;
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

// ----- design/rgb565_to_int8_tensor_pixel_unit.sv -----
// Top level of the RGB565 to int8 pixel unit: config registers, decode stage,
// three channel quantizers and the result register. Uses rgbq_pkg,
// rgbq_decode and rgbq_chan.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+----------------------
//  request   | i_start, o_busy, i_req                 | taken when start & !busy
//  result    | o_valid, o_res                         | one-cycle strobe
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data        | write when we is high
//
// One request per cycle; each result passes through the decode stage and
// the three channel stages (multiply, shift/clip, zero point/saturate).
// o_busy stays low. Reset clears the valid pipeline and loads the config
// reset values.
`default_nettype none
module rgb565_to_int8_tensor_pixel_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire rgbq_pkg::t_pixel_req i_req,
    output logic                      o_valid,
    output rgbq_pkg::t_pixel_res      o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);
    import rgbq_pkg::*;

    logic [31:0]       r_quant_multiplier;
    logic [4:0]        r_quant_shift;
    logic signed [7:0] r_zero_point;

    logic              dec_valid;
    t_chan_op          op_red, op_green, op_blue;
    logic [14:0]       dec_offset;
    logic [PIPE_DEPTH-2:0] r_valid;
    logic [14:0]       r_offset [PIPE_DEPTH-1];
    logic signed [7:0] red_value, green_value, blue_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_multiplier <= 32'd1;
            r_quant_shift      <= 5'd0;
            r_zero_point       <= 8'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUANT_MULTIPLIER: r_quant_multiplier <= i_cfg_data;
                CFG_QUANT_SHIFT:      r_quant_shift      <= i_cfg_data[4:0];
                CFG_ZERO_POINT:       r_zero_point       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    rgbq_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_start),
        .i_req         (i_req),
        .i_quant_shift (r_quant_shift),
        .o_valid       (dec_valid),
        .o_red         (op_red),
        .o_green       (op_green),
        .o_blue        (op_blue),
        .o_offset      (dec_offset)
    );

    rgbq_chan u_red (
        .i_clk              (i_clk),
        .i_op               (op_red),
        .i_quant_multiplier (r_quant_multiplier),
        .i_zero_point       (r_zero_point),
        .o_value            (red_value)
    );

    rgbq_chan u_green (
        .i_clk              (i_clk),
        .i_op               (op_green),
        .i_quant_multiplier (r_quant_multiplier),
        .i_zero_point       (r_zero_point),
        .o_value            (green_value)
    );

    rgbq_chan u_blue (
        .i_clk              (i_clk),
        .i_op               (op_blue),
        .i_quant_multiplier (r_quant_multiplier),
        .i_zero_point       (r_zero_point),
        .o_value            (blue_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[PIPE_DEPTH-3:0], dec_valid};
        end
        r_offset[0] <= dec_offset;
        for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
            r_offset[k] <= r_offset[k-1];
        end
    end

    assign o_busy             = 1'b0;
    assign o_valid            = r_valid[PIPE_DEPTH-2];
    assign o_res.plane_offset = r_offset[PIPE_DEPTH-2];
    assign o_res.red_value    = red_value;
    assign o_res.green_value  = green_value;
    assign o_res.blue_value   = blue_value;

endmodule
`default_nettype wire

// ----- design/rgbq_checker.sv -----
// Port-level checker for the RGB565 to int8 pixel unit, bound to the top
// level. Uses rgbq_pkg.
`default_nettype none
module rgbq_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_start,
    input wire logic                 o_busy,
    input wire rgbq_pkg::t_pixel_req i_req,
    input wire logic                 o_valid,
    input wire rgbq_pkg::t_pixel_res o_res
);
    import rgbq_pkg::*;

    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_valid)
        else $error("accepted request produced no result");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 4))
        else $error("result without a matching request");

    a_offset_tracks_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.plane_offset == $past(plane_offset_of(i_req.pixel_index), 4)))
        else $error("plane offset does not match request index");

endmodule

bind rgb565_to_int8_tensor_pixel_unit rgbq_checker u_rgbq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_req   (i_req),
    .o_valid (o_valid),
    .o_res   (o_res)
);
`default_nettype wire
